[hdl/ssot_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssot_pkg: shared types and constants for the sliding slot outcome tally
// Field widths, counter store geometry and request codes.
// ----------------------------------------------------------------------------
package ssot_pkg;

    localparam int SLOTS      = 5;
    localparam int PEERS      = 64;
    localparam int COUNT_BITS = 16;

    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int PEER_IDX_W = $clog2(PEERS);
    localparam int ADDR_W     = SLOT_W + PEER_IDX_W;
    localparam int MEM_DEPTH  = SLOTS * (2 ** PEER_IDX_W);
    localparam int EPOCH_W    = 32;

    localparam int TIME_W     = 32;
    localparam int PEER_W     = 6;
    localparam int DELAY_W    = 16;
    localparam int RSLOT_W    = 3;
    localparam int OUT_CNT_W  = 16;
    localparam int SLOTS_W    = 3;
    localparam int WIN_W      = 20;
    localparam int MODE_W     = 2;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 72;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic REQ_RECORD = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    localparam logic [MODE_W-1:0] MODE_HONEST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FAIL    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUCCEED = 2'd2;

    localparam logic [1:0] REG_WINDOW = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic [WIN_W-1:0]   WINDOW_RST = 20'd1000;
    localparam logic [DELAY_W-1:0] LIMIT_RST  = 16'd100;

    typedef struct packed {
        logic [EPOCH_W-1:0]    epoch;
        logic [COUNT_BITS-1:0] good;
        logic [COUNT_BITS-1:0] bad;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_entry            data;
    } t_wr_req;

endpackage
`default_nettype wire

[hdl/sliding_slot_peer_outcome_tally.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_slot_peer_outcome_tally: time-slotted good/bad tally per peer
// Records judged service outcomes into a ring of time slots and reads back
// one slot's counters for a peer.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake            Contents
// s_axis    in   tvalid/tready        tuser: req_type; tdata: request fields
// m_axis    out  tvalid/tready        tdata: one result per request
// apb       in   psel/penable/pready  window, judge mode, delay limit
//
// Three stages: input register, slot update plus counter read, counter
// write plus result register. One transaction per cycle when the sink keeps
// up. After reset a zeroing pass over all SLOTS*2^clog2(PEERS) entries (320)
// of the counter store holds s_axis_tready low. A stalled result freezes all
// stages.
// ----------------------------------------------------------------------------
module sliding_slot_peer_outcome_tally (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [31:0] now_ms, [37:32] peer, [53:38] response_delay_ms, [56:54] read_slot
    input  wire logic [ssot_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [0] req_type
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [0] success, [3:1] slots_in_use, [19:4] good_count, [35:20] bad_count,
    // [67:36] slot_start_ms, [68] entry_valid
    output logic [ssot_pkg::M_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssot_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ssot_pkg::PDATA_W-1:0]  pwdata,
    output logic [ssot_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);
    import ssot_pkg::*;

    function automatic logic [SLOT_W-1:0] ring_pos(input logic [SLOT_W-1:0] ptr,
                                                   input logic [SLOT_W-1:0] age);
        logic [SLOT_W:0] sum;
        sum = {1'b0, ptr} + {1'b0, age};
        if (sum >= (SLOT_W + 1)'(SLOTS)) begin
            sum = sum - (SLOT_W + 1)'(SLOTS);
        end
        return sum[SLOT_W-1:0];
    endfunction

    // configuration
    logic [WIN_W-1:0]   r_window;
    logic [MODE_W-1:0]  r_mode;
    logic [DELAY_W-1:0] r_limit;
    logic               cfg_wr;

    // slot ring
    logic [TIME_W-1:0]  r_start     [SLOTS];
    logic [EPOCH_W-1:0] r_slot_epoch[SLOTS];
    logic [EPOCH_W-1:0] r_epoch;
    logic [SLOT_W-1:0]  r_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [EPOCH_W-1:0] n_epoch;
    logic [SLOT_W-1:0]  n_ptr;
    logic [CNT_W-1:0]   n_count;

    // stage A
    logic               r_a_vld;
    logic               r_a_req;
    logic [TIME_W-1:0]  r_a_now;
    logic [PEER_W-1:0]  r_a_peer;
    logic [DELAY_W-1:0] r_a_delay;
    logic [RSLOT_W-1:0] r_a_rslot;

    // stage B
    logic               r_b_vld;
    logic               r_b_req;
    logic               r_b_succ;
    logic [TIME_W-1:0]  r_b_start;
    logic [EPOCH_W-1:0] r_b_epoch;
    logic [CNT_W-1:0]   r_b_count;
    logic               r_b_valid;
    logic [ADDR_W-1:0]  r_b_addr;

    // result register
    logic                 r_out_vld;
    logic                 r_out_succ;
    logic [SLOTS_W-1:0]   r_out_slots;
    logic [OUT_CNT_W-1:0] r_out_good;
    logic [OUT_CNT_W-1:0] r_out_bad;
    logic [TIME_W-1:0]    r_out_start;
    logic                 r_out_valid;

    logic               advance;
    logic               ram_busy;
    t_rd_req            rd_req;
    t_wr_req            wr_req;
    t_entry             ram_q;

    // stage A logic
    logic               is_rec;
    logic               judge;
    logic               peer_ok;
    logic [SLOT_W-1:0]  newest;
    logic [SLOT_W-1:0]  rd_pos;
    logic [SLOT_W-1:0]  sel_pos;
    logic [SLOT_W-1:0]  new_pos;
    logic [SLOT_W-1:0]  pos;
    logic [TIME_W-1:0]  sel_start;
    logic [EPOCH_W-1:0] sel_epoch;
    logic [TIME_W-1:0]  age;
    logic               fresh;
    logic               open_slot;
    logic               full;
    logic [EPOCH_W-1:0] epoch_inc;
    logic               a_valid;

    // stage B logic
    logic                  live;
    logic [COUNT_BITS-1:0] cur_good;
    logic [COUNT_BITS-1:0] cur_bad;
    logic [COUNT_BITS-1:0] new_good;
    logic [COUNT_BITS-1:0] new_bad;
    logic [COUNT_BITS-1:0] res_good;
    logic [COUNT_BITS-1:0] res_bad;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
            r_mode   <= MODE_HONEST;
            r_limit  <= LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_WINDOW: r_window <= pwdata[WIN_W-1:0];
                REG_MODE:   r_mode   <= pwdata[MODE_W-1:0];
                REG_LIMIT:  r_limit  <= pwdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WINDOW: prdata = PDATA_W'(r_window);
            REG_MODE:   prdata = PDATA_W'(r_mode);
            REG_LIMIT:  prdata = PDATA_W'(r_limit);
            default:    prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    assign advance       = !r_out_vld || m_axis_tready;
    assign s_axis_tready = advance && !ram_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (advance) begin
            r_a_vld <= s_axis_tvalid && s_axis_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a_req   <= s_axis_tuser;
            r_a_now   <= s_axis_tdata[31:0];
            r_a_peer  <= s_axis_tdata[37:32];
            r_a_delay <= s_axis_tdata[53:38];
            r_a_rslot <= s_axis_tdata[56:54];
        end
    end

    // ---------------- stage A: judge, slot selection ----------------
    assign is_rec  = (r_a_req == REQ_RECORD);
    assign peer_ok = (int'(r_a_peer) < PEERS);

    always_comb begin
        case (r_mode)
            MODE_FAIL:    judge = 1'b0;
            MODE_SUCCEED: judge = 1'b1;
            default:      judge = (r_a_delay <= r_limit);
        endcase
    end

    assign newest    = ring_pos(r_ptr, SLOT_W'(r_count - CNT_W'(1)));
    assign rd_pos    = ring_pos(r_ptr, SLOT_W'(r_a_rslot));
    assign sel_pos   = is_rec ? newest : rd_pos;
    assign sel_start = r_start[sel_pos];
    assign sel_epoch = r_slot_epoch[sel_pos];
    assign age       = r_a_now - sel_start;
    assign fresh     = (r_count == '0) || (age >= TIME_W'(r_window));
    assign open_slot = is_rec && fresh;
    assign full      = (r_count == CNT_W'(SLOTS));
    assign new_pos   = full ? r_ptr : ring_pos(r_ptr, SLOT_W'(r_count));
    assign pos       = open_slot ? new_pos : sel_pos;
    assign epoch_inc = (r_epoch + EPOCH_W'(1) == '0) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
    assign a_valid   = is_rec ? peer_ok : (peer_ok && (r_a_rslot < r_count));

    always_comb begin
        n_epoch = r_epoch;
        n_ptr   = r_ptr;
        n_count = r_count;
        if (open_slot) begin
            n_epoch = epoch_inc;
            if (full) begin
                n_ptr = ring_pos(r_ptr, SLOT_W'(1));
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_start[i]      <= '0;
                r_slot_epoch[i] <= '0;
            end
            r_epoch <= '0;
            r_ptr   <= '0;
            r_count <= '0;
        end else if (advance && r_a_vld) begin
            if (open_slot) begin
                r_start[new_pos]      <= r_a_now;
                r_slot_epoch[new_pos] <= epoch_inc;
            end
            r_epoch <= n_epoch;
            r_ptr   <= n_ptr;
            r_count <= n_count;
        end
    end

    assign rd_req.en   = advance && r_a_vld;
    assign rd_req.addr = {pos, r_a_peer[PEER_IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (advance) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_b_req   <= r_a_req;
            r_b_succ  <= is_rec && judge;
            r_b_start <= open_slot ? r_a_now : sel_start;
            r_b_epoch <= open_slot ? epoch_inc : sel_epoch;
            r_b_count <= is_rec ? n_count : r_count;
            r_b_valid <= a_valid;
            r_b_addr  <= rd_req.addr;
        end
    end

    // ---------------- counter store ----------------
    ssot_tally_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (rd_req),
        .i_wr    (wr_req),
        .o_q     (ram_q),
        .o_busy  (ram_busy)
    );

    // ---------------- stage B: count update ----------------
    // entries tagged with an older epoch belong to a slot that was reopened
    assign live     = (ram_q.epoch == r_b_epoch);
    assign cur_good = live ? ram_q.good : '0;
    assign cur_bad  = live ? ram_q.bad  : '0;
    assign new_good = (r_b_succ && (cur_good != '1)) ? cur_good + COUNT_BITS'(1) : cur_good;
    assign new_bad  = (!r_b_succ && (cur_bad != '1)) ? cur_bad + COUNT_BITS'(1) : cur_bad;
    assign res_good = (r_b_req == REQ_RECORD) ? new_good : cur_good;
    assign res_bad  = (r_b_req == REQ_RECORD) ? new_bad  : cur_bad;

    assign wr_req.en         = advance && r_b_vld && (r_b_req == REQ_RECORD) && r_b_valid;
    assign wr_req.addr       = r_b_addr;
    assign wr_req.data.epoch = r_b_epoch;
    assign wr_req.data.good  = new_good;
    assign wr_req.data.bad   = new_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_succ  <= r_b_succ;
            r_out_slots <= SLOTS_W'(r_b_count);
            r_out_good  <= r_b_valid ? OUT_CNT_W'(res_good) : '0;
            r_out_bad   <= r_b_valid ? OUT_CNT_W'(res_bad) : '0;
            r_out_start <= ((r_b_req == REQ_RECORD) || r_b_valid) ? r_b_start : '0;
            r_out_valid <= r_b_valid;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out_valid, r_out_start, r_out_bad, r_out_good,
                            r_out_slots, r_out_succ};

endmodule
`default_nettype wire

[hdl/ssot_tally_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssot_tally_ram: per-slot, per-peer counter store
// One write and one registered read per cycle, write-to-read bypass, and a
// zeroing pass over every entry after reset.
// ----------------------------------------------------------------------------
module ssot_tally_ram (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ssot_pkg::t_rd_req i_rd,
    input  wire ssot_pkg::t_wr_req i_wr,
    output ssot_pkg::t_entry      o_q,
    output logic                  o_busy
);
    import ssot_pkg::*;

    t_entry            r_mem [MEM_DEPTH];
    t_entry            r_q;
    t_entry            r_fwd;
    logic              r_hit;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;

    assign wr_en   = r_busy | i_wr.en;
    assign wr_addr = r_busy ? r_clr_addr : i_wr.addr;
    assign wr_data = r_busy ? '0 : i_wr.data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_rd.en) begin
            r_q   <= r_mem[i_rd.addr];
            r_fwd <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (r_busy) begin
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    r_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_rd.en) begin
                r_hit <= i_wr.en && (i_wr.addr == i_rd.addr);
            end
        end
    end

    assign o_q    = r_hit ? r_fwd : r_q;
    assign o_busy = r_busy;

endmodule
`default_nettype wire

[tb/sv/sliding_slot_peer_outcome_tally_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_slot_peer_outcome_tally_tb: self-checking bench for the slot tally
// Drives record and read requests through the stream input. Changes the
// window, judge mode and delay limit over the APB port between phases.
// Every result is checked field by field against an in-bench model of the
// slot ring and the per-peer counters. Covers slot drop, zero-length and
// very long windows, all judge modes and time wraparound. Both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module sliding_slot_peer_outcome_tally_tb;

    import ssot_pkg::*;

    localparam int RANDOM_PER_PHASE = 70;
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_BITS) - 1);

    typedef struct {
        logic               req;
        logic [TIME_W-1:0]  now;
        logic [PEER_W-1:0]  peer;
        logic [DELAY_W-1:0] delay;
        logic [RSLOT_W-1:0] rslot;
    } t_req;

    typedef struct {
        logic                 success;
        logic [SLOTS_W-1:0]   slots;
        logic [OUT_CNT_W-1:0] good;
        logic [OUT_CNT_W-1:0] bad;
        logic [TIME_W-1:0]    start;
        logic                 valid;
    } t_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    sliding_slot_peer_outcome_tally i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow registers and slot ring state
    logic [WIN_W-1:0]   cfg_window = WINDOW_RST;
    logic [MODE_W-1:0]  cfg_mode = MODE_HONEST;
    logic [DELAY_W-1:0] cfg_limit = LIMIT_RST;
    logic [TIME_W-1:0]  slot_start [SLOTS];
    logic [31:0]        good_cnt [SLOTS][PEERS];
    logic [31:0]        bad_cnt [SLOTS][PEERS];
    int unsigned        oldest_pos = 0;
    int unsigned        open_slots = 0;

    t_req        req_backlog [$];
    t_result     owed_results [$];
    t_req        cur_req;
    logic [31:0] clock_ms = '0;

    int errors = 0;
    int n_record = 0, n_read = 0, n_open = 0, n_drop = 0, n_sat = 0;
    int n_checked = 0, n_writes = 0;

    function automatic t_result tally_predict(t_req r);
        t_result     res;
        int unsigned pos;
        logic        fresh;
        logic [31:0] age;
        res = '{default: '0};
        if (r.req == REQ_RECORD) begin
            n_record++;
            case (cfg_mode)
                MODE_FAIL:    res.success = 1'b0;
                MODE_SUCCEED: res.success = 1'b1;
                default:      res.success = (r.delay <= cfg_limit);
            endcase
            fresh = 1'b1;
            if (open_slots > 0) begin
                age = r.now - slot_start[(oldest_pos + open_slots - 1) % SLOTS];
                if (age < {12'b0, cfg_window})
                    fresh = 1'b0;
            end
            if (fresh) begin
                n_open++;
                if (open_slots < SLOTS) begin
                    open_slots++;
                end else begin
                    oldest_pos = (oldest_pos + 1) % SLOTS;
                    n_drop++;
                end
            end
            pos = (oldest_pos + open_slots - 1) % SLOTS;
            if (fresh) begin
                slot_start[pos] = r.now;
                for (int p = 0; p < PEERS; p++) begin
                    good_cnt[pos][p] = '0;
                    bad_cnt[pos][p] = '0;
                end
            end
            res.start = slot_start[pos];
            if (r.peer < PEERS) begin
                if (res.success) begin
                    if (good_cnt[pos][r.peer] < CNT_MAX) good_cnt[pos][r.peer]++;
                    else n_sat++;
                end else begin
                    if (bad_cnt[pos][r.peer] < CNT_MAX) bad_cnt[pos][r.peer]++;
                    else n_sat++;
                end
                res.good = good_cnt[pos][r.peer][OUT_CNT_W-1:0];
                res.bad = bad_cnt[pos][r.peer][OUT_CNT_W-1:0];
                res.valid = 1'b1;
            end
        end else begin
            n_read++;
            if (r.rslot < open_slots && r.peer < PEERS) begin
                pos = (oldest_pos + r.rslot) % SLOTS;
                res.good = good_cnt[pos][r.peer][OUT_CNT_W-1:0];
                res.bad = bad_cnt[pos][r.peer][OUT_CNT_W-1:0];
                res.start = slot_start[pos];
                res.valid = 1'b1;
            end
        end
        res.slots = open_slots[SLOTS_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            errors++;
        end
    endfunction

    // sender: bursts of random length with random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                owed_results = {owed_results, tally_predict(cur_req)};
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    cur_req = req_backlog.pop_front();
                    s_axis_tdata <= {7'b0, cur_req.rslot, cur_req.delay, cur_req.peer,
                                     cur_req.now};
                    s_axis_tuser <= cur_req.req;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern and result check
    int next_hold = 100;
    int hold_left = 0;
    int rx_mode = 0;
    int mode_left = 0;

    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.success = m_axis_tdata[0];
                got.slots   = m_axis_tdata[3:1];
                got.good    = m_axis_tdata[19:4];
                got.bad     = m_axis_tdata[35:20];
                got.start   = m_axis_tdata[67:36];
                got.valid   = m_axis_tdata[68];
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    n_checked++;
                    check_field("success", 32'(want.success), 32'(got.success));
                    check_field("slots_in_use", 32'(want.slots), 32'(got.slots));
                    check_field("good_count", 32'(want.good), 32'(got.good));
                    check_field("bad_count", 32'(want.bad), 32'(got.bad));
                    check_field("slot_start_ms", want.start, got.start);
                    check_field("entry_valid", 32'(want.valid), 32'(got.valid));
                end
            end
            // long hold-off so the pipeline fills and back-pressures the input
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (n_checked >= next_hold) begin
                next_hold += 150;
                hold_left = 60;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 80);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= ($urandom_range(0, 9) < 7);
                    default: m_axis_tready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WINDOW: cfg_window = val[WIN_W-1:0];
            REG_MODE:   cfg_mode = val[MODE_W-1:0];
            REG_LIMIT:  cfg_limit = val[DELAY_W-1:0];
            default:    ;
        endcase
        n_writes++;
    endtask

    task automatic push_record(input logic [31:0] now, input int peer, input int delay);
        t_req r;
        r = '{req: REQ_RECORD, now: now, peer: PEER_W'(peer), delay: DELAY_W'(delay),
              rslot: RSLOT_W'($urandom)};
        req_backlog = {req_backlog, r};
    endtask

    task automatic push_read(input int peer, input int rslot);
        t_req r;
        r = '{req: REQ_READ, now: $urandom, peer: PEER_W'(peer), delay: DELAY_W'($urandom),
              rslot: RSLOT_W'(rslot)};
        req_backlog = {req_backlog, r};
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || s_axis_tvalid || owed_results.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        int unsigned win, sel, pk, delay;
        for (int i = 0; i < n; i++) begin
            win = cfg_window;
            sel = $urandom_range(0, 99);
            pk = ($urandom_range(0, 2) == 0) ? $urandom_range(0, PEERS - 1)
                                             : $urandom_range(0, 3);
            if (sel < 8) begin
                // noise: unrelated time stamps and fully random fields
                if ($urandom_range(0, 1) == 0)
                    push_record($urandom, $urandom_range(0, 63), $urandom_range(0, 65535));
                else
                    push_read($urandom_range(0, 63), $urandom_range(0, 7));
            end else if (sel < 35) begin
                push_read(pk, ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
                                                         : $urandom_range(5, 7));
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: clock_ms += $urandom_range(0, win / 4);
                    7, 8:                clock_ms += win + $urandom_range(0, win);
                    default:             clock_ms += $urandom;
                endcase
                case ($urandom_range(0, 4))
                    0: delay = 0;
                    1: delay = 65535;
                    2: begin
                        delay = cfg_limit + $urandom_range(0, 2);
                        delay = (delay == 0) ? 0 : delay - 1;
                        if (delay > 65535) delay = 65535;
                    end
                    default: delay = $urandom_range(0, 65535);
                endcase
                push_record(clock_ms, pk, delay);
            end
        end
    endtask

    int unsigned phase_win [6] = '{50, 0, 1, 1000000, 200, 5000};
    int unsigned phase_mode [6] = '{0, 1, 2, 3, 0, 0};
    int unsigned phase_limit [6] = '{300, 0, 65535, 1000, 65535, 0};

    initial begin
        for (int s = 0; s < SLOTS; s++) begin
            slot_start[s] = '0;
            for (int p = 0; p < PEERS; p++) begin
                good_cnt[s][p] = '0;
                bad_cnt[s][p] = '0;
            end
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset register values: window 1000, honest, limit 100
        push_read(0, 0);
        push_record(32'd0, 0, 0);
        push_record(32'd999, 0, 100);
        push_record(32'd500, 63, 101);
        push_record(32'd998, 63, 65535);
        push_record(32'd1000, 0, 50);
        push_record(32'd2500, 0, 100);
        push_record(32'd3600, 63, 0);
        push_record(32'd4700, 0, 101);
        for (int k = 0; k < 8; k++)
            push_read(0, k);
        push_record(32'd6000, 63, 1);
        push_read(63, 0);
        push_read(63, 4);
        push_record(32'hFFFF_FF00, 63, 7);
        push_record(32'h0000_0100, 63, 65535);
        push_read(63, 4);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            apb_write(REG_WINDOW, phase_win[ph]);
            apb_write(REG_MODE, phase_mode[ph]);
            apb_write(REG_LIMIT, phase_limit[ph]);
            if (ph == 4)
                apb_write(REG_UNUSED, 32'hFFFF_FFFF);
            queue_random(RANDOM_PER_PHASE);
            wait_idle();
        end

        $display("Covered %0d records and %0d reads over %0d register writes: %0d slots opened,",
                 n_record, n_read, n_writes, n_open);
        $display("%0d oldest slots dropped, %0d saturated increments; %0d results checked",
                 n_drop, n_sat, n_checked);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20000000;
        $display("Timeout with %0d results still owed", owed_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/ssot_pkg.sv
hdl/ssot_tally_ram.sv
hdl/sliding_slot_peer_outcome_tally.sv
tb/sv/sliding_slot_peer_outcome_tally_tb.sv
